// ----- hdl/spos_pkg.sv -----
// Shared constants, field widths and controller/datapath interface types.
`timescale 1ns / 1ps
package spos_pkg;

  localparam int DEF_MAX_NODES = 2048;
  localparam int DEF_MAX_EDGES = 16384;
  localparam int DEF_ID_SPACE  = 32768;

  localparam int KIND_W   = 3;
  localparam int NODE_W   = 11;
  localparam int WEIGHT_W = 16;
  localparam int ID_W     = 15;
  localparam int REV_W    = 20;
  localparam int CFG_W    = 12;
  localparam int DIST_W   = 32;

  localparam logic [DIST_W-1:0] DIST_UNREACHABLE = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_SATURATED   = {{(DIST_W-1){1'b1}}, 1'b0};

  localparam logic [KIND_W-1:0] KIND_ADD_EDGE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ROUTE       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_OFFER   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SELL        = 3'd4;

  typedef struct packed {
    logic accept;
    logic ctr_clr;
    logic ctr_inc;
    logic node_clr;
    logic node_start;
    logic scan_init;
    logic scan_rd;
    logic settle;
    logic edge_rd;
    logic tgt_rd;
    logic relax;
    logic offer_clr;
    logic offer_rd;
    logic sell_init;
    logic sell_wr;
    logic edge_wr;
    logic offer_add;
    logic offer_cancel;
    logic routed_set;
    logic result;
  } spos_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              node_last;
    logic              scan_last;
    logic              edge_last;
    logic              id_last;
    logic              scan_found;
    logic              start_ok;
    logic              edges_empty;
  } spos_stat_t;

endpackage

// ----- hdl/spos_datapath.sv -----
// Datapath with the edge, node and offer memories, scan pipelines and result register.
`timescale 1ns / 1ps
module spos_datapath import spos_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int ID_SPACE  = DEF_ID_SPACE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spos_cmd_t           cmd_i,
  output spos_stat_t          stat_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  input  logic [ID_W-1:0]     offer_id_i,
  input  logic [REV_W-1:0]    offer_revenue_i,
  output logic                found_o,
  output logic [ID_W-1:0]     sold_id_o,
  output logic                done_o
);

  localparam int NAW  = $clog2(MAX_NODES);
  localparam int LIMW = $clog2(MAX_NODES + 1);
  localparam int NCW  = (LIMW > CFG_W) ? LIMW : CFG_W;
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int IAW  = $clog2(ID_SPACE);
  localparam int MAXA = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
  localparam int MAXD = (MAXA > ID_SPACE) ? MAXA : ID_SPACE;
  localparam int CW   = $clog2(MAXD);
  localparam int NMW  = DIST_W + 1;
  localparam int EMW  = 2 * NODE_W + WEIGHT_W;
  localparam int OMW  = 1 + NODE_W + REV_W;

  logic [NMW-1:0] node_mem [MAX_NODES];
  logic [EMW-1:0] edge_mem [MAX_EDGES];
  logic [OMW-1:0] offer_mem [ID_SPACE];

  logic [NCW-1:0]      node_count_q;
  logic [LIMW-1:0]     lim;
  logic [CW-1:0]       ctr_q;
  logic [ECW-1:0]      edge_count_q;
  logic                routed_q;

  logic [KIND_W-1:0]   kind_q;
  logic [NODE_W-1:0]   a_q, b_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [ID_W-1:0]     id_q;
  logic [REV_W-1:0]    rev_q;

  logic [NMW-1:0]      nrd_q;
  logic [EMW-1:0]      erd_q;
  logic [OMW-1:0]      ord_q;

  logic                s1_v_q;
  logic [NAW-1:0]      s1_idx_q;
  logic [DIST_W-1:0]   bd_q;
  logic [NAW-1:0]      best_q;
  logic                scan_found_q;

  logic [NODE_W-1:0]   tgt_q;
  logic                hit_q;

  logic                o1_v_q, o2_v_q;
  logic [IAW-1:0]      o1_idx_q, o2_idx_q;
  logic                o2_live_q;
  logic [NODE_W-1:0]   o2_dest_q;
  logic [REV_W-1:0]    o2_val_q;
  logic                have_q;
  logic [REV_W-1:0]    bp_q;
  logic [IAW-1:0]      best_id_q;

  logic                found_q, done_q;
  logic [ID_W-1:0]     sold_q;

  logic [NODE_W-1:0]   e_from, e_to, tgt;
  logic [WEIGHT_W-1:0] e_len;
  logic                hit_from, hit_to;
  logic [DIST_W:0]     cand_wide;
  logic [DIST_W-1:0]   cand;
  logic [DIST_W-1:0]   o2_dist;
  logic [REV_W-1:0]    o2_profit;
  logic                o2_ok;

  logic                nwe;
  logic [NAW-1:0]      nwa, nra;
  logic [NMW-1:0]      nwd;
  logic                owe;
  logic [IAW-1:0]      owa;
  logic [OMW-1:0]      owd;
  logic                ewe;

  assign lim = (32'(node_count_q) > MAX_NODES) ? LIMW'(MAX_NODES) : LIMW'(node_count_q);

  assign e_from   = erd_q[EMW-1 -: NODE_W];
  assign e_to     = erd_q[WEIGHT_W +: NODE_W];
  assign e_len    = erd_q[WEIGHT_W-1:0];
  assign hit_from = (32'(e_from) == 32'(best_q));
  assign hit_to   = (32'(e_to) == 32'(best_q));
  assign tgt      = hit_from ? e_to : e_from;

  assign cand_wide = (DIST_W+1)'(bd_q) + (DIST_W+1)'(e_len);
  assign cand      = (cand_wide >= (DIST_W+1)'(DIST_UNREACHABLE)) ? DIST_SATURATED
                                                                  : cand_wide[DIST_W-1:0];

  assign o2_dist   = nrd_q[DIST_W-1:0];
  assign o2_profit = o2_val_q - o2_dist[REV_W-1:0];
  assign o2_ok     = o2_v_q && o2_live_q && routed_q && (32'(o2_dest_q) < 32'(lim)) &&
                     (o2_dist != DIST_UNREACHABLE) && (o2_dist <= DIST_W'(o2_val_q)) &&
                     (!have_q || (o2_profit > bp_q));

  always_comb begin
    nwe = 1'b0;
    nwa = NAW'(ctr_q);
    nwd = {1'b0, DIST_UNREACHABLE};
    if (cmd_i.node_clr) begin
      nwe = 1'b1;
    end else if (cmd_i.node_start) begin
      nwe = 1'b1;
      nwa = NAW'(a_q);
      nwd = '0;
    end else if (cmd_i.settle) begin
      nwe = 1'b1;
      nwa = best_q;
      nwd = {1'b1, bd_q};
    end else if (cmd_i.relax) begin
      nwe = hit_q && (32'(tgt_q) < 32'(lim)) && !nrd_q[DIST_W] &&
            (cand < nrd_q[DIST_W-1:0]);
      nwa = NAW'(tgt_q);
      nwd = {1'b0, cand};
    end
  end

  always_comb begin
    if (cmd_i.scan_rd) begin
      nra = NAW'(ctr_q);
    end else if (cmd_i.tgt_rd) begin
      nra = NAW'(tgt);
    end else begin
      nra = NAW'(ord_q[REV_W +: NODE_W]);
    end
  end

  always_comb begin
    owe = 1'b0;
    owa = IAW'(ctr_q);
    owd = '0;
    if (cmd_i.offer_clr) begin
      owe = 1'b1;
    end else if (cmd_i.offer_add) begin
      owe = (32'(id_q) < ID_SPACE);
      owa = IAW'(id_q);
      owd = {1'b1, a_q, rev_q};
    end else if (cmd_i.offer_cancel) begin
      owe = (32'(id_q) < ID_SPACE);
      owa = IAW'(id_q);
    end else if (cmd_i.sell_wr) begin
      owe = have_q;
      owa = best_id_q;
    end
  end

  assign ewe = cmd_i.edge_wr && (32'(edge_count_q) < MAX_EDGES);

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      node_mem[nwa] <= nwd;
    end
    nrd_q <= node_mem[nra];
  end

  always_ff @(posedge clk_i) begin
    if (ewe) begin
      edge_mem[EAW'(edge_count_q)] <= {a_q, b_q, w_q};
    end
    if (cmd_i.edge_rd) begin
      erd_q <= edge_mem[EAW'(ctr_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (owe) begin
      offer_mem[owa] <= owd;
    end
    ord_q <= offer_mem[IAW'(ctr_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      w_q    <= edge_weight_i;
      id_q   <= offer_id_i;
      rev_q  <= offer_revenue_i;
    end
    s1_idx_q <= NAW'(ctr_q);
    o1_idx_q <= IAW'(ctr_q);
    o2_idx_q <= o1_idx_q;
    o2_live_q <= ord_q[OMW-1];
    o2_dest_q <= ord_q[REV_W +: NODE_W];
    o2_val_q  <= ord_q[REV_W-1:0];
    if (cmd_i.tgt_rd) begin
      tgt_q <= tgt;
      hit_q <= hit_from || hit_to;
    end
    if (cmd_i.scan_init) begin
      bd_q <= DIST_UNREACHABLE;
    end else if (s1_v_q && !nrd_q[DIST_W] && (nrd_q[DIST_W-1:0] < bd_q)) begin
      bd_q   <= nrd_q[DIST_W-1:0];
      best_q <= s1_idx_q;
    end
    if (o2_ok) begin
      bp_q      <= o2_profit;
      best_id_q <= o2_idx_q;
    end
    if (cmd_i.result) begin
      found_q <= have_q;
      sold_q  <= have_q ? ID_W'(best_id_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NCW'(MAX_NODES);
      ctr_q        <= '0;
      edge_count_q <= '0;
      routed_q     <= 1'b0;
      s1_v_q       <= 1'b0;
      scan_found_q <= 1'b0;
      o1_v_q       <= 1'b0;
      o2_v_q       <= 1'b0;
      have_q       <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= NCW'(cfg_wdata_i);
      end
      if (cmd_i.ctr_clr || cmd_i.scan_init) begin
        ctr_q <= '0;
      end else if (cmd_i.ctr_inc) begin
        ctr_q <= ctr_q + CW'(1);
      end
      if (ewe) begin
        edge_count_q <= edge_count_q + ECW'(1);
      end
      if (cmd_i.routed_set) begin
        routed_q <= 1'b1;
      end
      s1_v_q <= cmd_i.scan_rd;
      if (cmd_i.scan_init) begin
        scan_found_q <= 1'b0;
      end else if (s1_v_q && !nrd_q[DIST_W] && (nrd_q[DIST_W-1:0] < bd_q)) begin
        scan_found_q <= 1'b1;
      end
      o1_v_q <= cmd_i.offer_rd;
      o2_v_q <= o1_v_q;
      if (cmd_i.sell_init) begin
        have_q <= 1'b0;
      end else if (o2_ok) begin
        have_q <= 1'b1;
      end
      done_q <= cmd_i.result;
    end
  end

  assign stat_o.kind        = kind_q;
  assign stat_o.node_last   = (32'(ctr_q) == MAX_NODES - 1);
  assign stat_o.scan_last   = (32'(ctr_q) == 32'(lim) - 32'd1);
  assign stat_o.edge_last   = (32'(ctr_q) == 32'(edge_count_q) - 32'd1);
  assign stat_o.id_last     = (32'(ctr_q) == ID_SPACE - 1);
  assign stat_o.scan_found  = scan_found_q;
  assign stat_o.start_ok    = (32'(a_q) < 32'(lim));
  assign stat_o.edges_empty = (edge_count_q == '0);

  assign found_o   = found_q;
  assign sold_id_o = sold_q;
  assign done_o    = done_q;

  a_sold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !found_q |-> sold_q == '0) else $error("sold id not zero on miss");
  a_edge_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_count_q) <= MAX_EDGES) else $error("edge count beyond capacity");
  a_scan_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_found_q |-> bd_q != DIST_UNREACHABLE) else $error("settled node unreachable");
  a_result_after_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.sell_wr)) else $error("result without offer write-back");

endmodule

// ----- hdl/spos_controller.sv -----
// Controller state machine sequencing requests, route scans and the sell scan.
`timescale 1ns / 1ps
module spos_controller import spos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  spos_stat_t stat_i,
  output spos_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_R_CLR, ST_R_INIT, ST_SCAN, ST_DRAIN, ST_SETTLE,
    ST_E_RD, ST_E_TGT, ST_E_RLX, ST_S_SCAN, ST_S_DRAIN1, ST_S_DRAIN2, ST_S_WR
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.offer_clr = 1'b1;
        cmd_o.ctr_inc   = 1'b1;
        if (stat_i.id_last) begin
          cmd_o.ctr_clr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        case (stat_i.kind)
          KIND_ADD_EDGE: cmd_o.edge_wr = 1'b1;
          KIND_ROUTE: begin
            cmd_o.ctr_clr = 1'b1;
            state_d = ST_R_CLR;
          end
          KIND_ADD_OFFER: cmd_o.offer_add = 1'b1;
          KIND_CANCEL: cmd_o.offer_cancel = 1'b1;
          KIND_SELL: begin
            cmd_o.ctr_clr   = 1'b1;
            cmd_o.sell_init = 1'b1;
            state_d = ST_S_SCAN;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_R_CLR: begin
        cmd_o.node_clr = 1'b1;
        cmd_o.ctr_inc  = 1'b1;
        if (stat_i.node_last) begin
          state_d = ST_R_INIT;
        end
      end
      ST_R_INIT: begin
        cmd_o.routed_set = 1'b1;
        if (stat_i.start_ok) begin
          cmd_o.node_start = 1'b1;
          cmd_o.scan_init  = 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.ctr_inc = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_SETTLE;
      ST_SETTLE: begin
        if (stat_i.scan_found) begin
          cmd_o.settle  = 1'b1;
          cmd_o.ctr_clr = 1'b1;
          if (stat_i.edges_empty) begin
            cmd_o.scan_init = 1'b1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_E_RD;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_E_RD: begin
        cmd_o.edge_rd = 1'b1;
        state_d = ST_E_TGT;
      end
      ST_E_TGT: begin
        cmd_o.tgt_rd = 1'b1;
        state_d = ST_E_RLX;
      end
      ST_E_RLX: begin
        cmd_o.relax   = 1'b1;
        cmd_o.ctr_inc = 1'b1;
        if (stat_i.edge_last) begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_E_RD;
        end
      end
      ST_S_SCAN: begin
        cmd_o.offer_rd = 1'b1;
        cmd_o.ctr_inc  = 1'b1;
        if (stat_i.id_last) begin
          state_d = ST_S_DRAIN1;
        end
      end
      ST_S_DRAIN1: state_d = ST_S_DRAIN2;
      ST_S_DRAIN2: state_d = ST_S_WR;
      ST_S_WR: begin
        cmd_o.sell_wr = 1'b1;
        cmd_o.result  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- hdl/shortest_path_offer_selector_unit.sv -----
// Top level of the shortest-path offer selector: controller plus datapath.
// Add edge, add offer, cancel offer and unused kinds keep busy high for one cycle. Route:
// clears the node table and seeds the start, then scans the first limit nodes for the nearest
// unsettled one, settles it and relaxes its edges until none is left. Sell: scans every offer
// ID, result in the first idle cycle. One request at a time; the receiver cannot stall. The
// scans and edge walks set the rate. After reset busy is high while the offer table clears.
`timescale 1ns / 1ps
module shortest_path_offer_selector_unit import spos_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_EDGES = DEF_MAX_EDGES,
  parameter int ID_SPACE  = DEF_ID_SPACE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  input  logic [ID_W-1:0]     offer_id_i,
  input  logic [REV_W-1:0]    offer_revenue_i,
  output logic                done_o,
  output logic                found_o,
  output logic [ID_W-1:0]     sold_id_o
);

  spos_cmd_t  cmd;
  spos_stat_t stat;

  spos_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  spos_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .ID_SPACE  (ID_SPACE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .edge_weight_i   (edge_weight_i),
    .offer_id_i      (offer_id_i),
    .offer_revenue_i (offer_revenue_i),
    .found_o         (found_o),
    .sold_id_o       (sold_id_o),
    .done_o          (done_o)
  );

endmodule
